// ----- src/dmmlcd_pkg.sv -----
// Shared types, constants and the segment decode function of the meter frame decoder.
`default_nettype none

package dmmlcd_pkg;

   // Frame geometry.
   localparam int FrameLen = 14;
   localparam int StoreDepth = FrameLen - 1;
   localparam logic [3:0] LastIndex = 4'(FrameLen - 1);
   localparam logic [3:0] StartNibble = 4'h1;
   localparam logic [13:0] MaxMagnitude = 14'd9999;

   // Measurement mode codes.
   typedef enum logic [2:0] {
      MODE_NONE = 3'd0,
      MODE_DC   = 3'd1,
      MODE_AC   = 3'd2,
      MODE_TEMP = 3'd3,
      MODE_BEEP = 3'd4
   } mode_type;

   // Scale prefix codes.
   typedef enum logic [2:0] {
      PREFIX_NONE  = 3'd0,
      PREFIX_MICRO = 3'd1,
      PREFIX_NANO  = 3'd2,
      PREFIX_KILO  = 3'd3,
      PREFIX_MILLI = 3'd4,
      PREFIX_MEGA  = 3'd5
   } prefix_type;

   // Unit codes.
   typedef enum logic [3:0] {
      UNIT_NONE    = 4'd0,
      UNIT_DIODE   = 4'd1,
      UNIT_PERCENT = 4'd2,
      UNIT_FARAD   = 4'd3,
      UNIT_OHM     = 4'd4,
      UNIT_AMP     = 4'd5,
      UNIT_VOLT    = 4'd6,
      UNIT_HERTZ   = 4'd7,
      UNIT_CELSIUS = 4'd8
   } unit_type;

   // Input transfer payload.
   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   // Result transfer payload.
   typedef struct packed {
      logic [13:0] reading_magnitude;
      logic [1:0]  decimal_places;
      logic        negative;
      logic        reading_valid;
      mode_type    meas_mode;
      prefix_type  scale_prefix;
      unit_type    meas_unit;
      logic        auto_range;
   } rsp_type;

   // Values that persist from one frame to the next.
   typedef struct packed {
      mode_type    mode;
      prefix_type  prefix;
      unit_type    unit;
      logic [13:0] magnitude;
      logic [1:0]  decimals;
      logic        negative;
   } held_type;

   // One decoded seven-segment digit.
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   // Maps a 7-bit segment code to a digit; anything else is flagged as not a digit.
   function automatic digit_type seg_decode(input logic [6:0] code);
      digit_type d;
      d.ok = 1'b1;
      unique case (code)
         7'h7D: d.value = 4'd0;
         7'h05: d.value = 4'd1;
         7'h5B: d.value = 4'd2;
         7'h1F: d.value = 4'd3;
         7'h27: d.value = 4'd4;
         7'h3E: d.value = 4'd5;
         7'h7E: d.value = 4'd6;
         7'h15: d.value = 4'd7;
         7'h7F: d.value = 4'd8;
         7'h3F: d.value = 4'd9;
         default: begin
            d.ok = 1'b0;
            d.value = 4'd0;
         end
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- src/dmmlcd_chan_if.sv -----
// Valid/ready channel interface carrying one payload per transfer.
`default_nettype none

interface dmmlcd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/dmmlcd_decode.sv -----
// Combinational decode of one complete 14-byte meter frame.
`default_nettype none

module dmmlcd_decode (
   input  wire logic [7:0]         frame [dmmlcd_pkg::FrameLen],
   input  wire dmmlcd_pkg::held_type held,
   output dmmlcd_pkg::held_type    held_next,
   output dmmlcd_pkg::rsp_type     result
);

   dmmlcd_pkg::digit_type digits [4];
   logic       all_ok;
   logic [1:0] places;
   logic [13:0] magnitude;

   // Segment codes of the four digits, each split over two bytes.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         digits[k] = dmmlcd_pkg::seg_decode({frame[2*k+1][2:0], frame[2*k+2][3:0]});
      end
   end

   assign all_ok = digits[0].ok && digits[1].ok && digits[2].ok && digits[3].ok;

   // Digits weighted by their decade; constant multipliers only.
   assign magnitude = 14'(digits[0].value) * 14'd1000
                    + 14'(digits[1].value) * 14'd100
                    + 14'(digits[2].value) * 14'd10
                    + 14'(digits[3].value);

   // The decimal point flag of the latest digit pair wins.
   always_comb begin
      priority if (frame[7][3]) begin
         places = 2'd1;
      end else if (frame[5][3]) begin
         places = 2'd2;
      end else if (frame[3][3]) begin
         places = 2'd3;
      end else begin
         places = 2'd0;
      end
   end

   // Priority chains for mode, prefix and unit; no match keeps the held value.
   always_comb begin
      held_next = held;

      priority if (frame[0][2]) begin
         held_next.mode = dmmlcd_pkg::MODE_DC;
      end else if (frame[13][1]) begin
         held_next.mode = dmmlcd_pkg::MODE_TEMP;
         held_next.unit = dmmlcd_pkg::UNIT_CELSIUS;
      end else if (frame[0][3:0] != 4'd0) begin
         held_next.mode = dmmlcd_pkg::MODE_AC;
      end else if (frame[10][0]) begin
         held_next.mode = dmmlcd_pkg::MODE_BEEP;
      end else begin
         // No mode flag is set, so the held mode stands.
      end

      priority if (frame[9][3]) begin
         held_next.prefix = dmmlcd_pkg::PREFIX_MICRO;
      end else if (frame[9][2]) begin
         held_next.prefix = dmmlcd_pkg::PREFIX_NANO;
      end else if (frame[9][1]) begin
         held_next.prefix = dmmlcd_pkg::PREFIX_KILO;
      end else if (frame[10][3]) begin
         held_next.prefix = dmmlcd_pkg::PREFIX_MILLI;
      end else if (frame[10][1]) begin
         held_next.prefix = dmmlcd_pkg::PREFIX_MEGA;
      end else begin
         // No prefix flag is set, so the held prefix stands.
      end

      // The unit chain may override the temperature unit set above.
      priority if (frame[9][0]) begin
         held_next.unit = dmmlcd_pkg::UNIT_DIODE;
      end else if (frame[10][2]) begin
         held_next.unit = dmmlcd_pkg::UNIT_PERCENT;
      end else if (frame[11][3]) begin
         held_next.unit = dmmlcd_pkg::UNIT_FARAD;
      end else if (frame[11][2]) begin
         held_next.unit = dmmlcd_pkg::UNIT_OHM;
      end else if (frame[12][3]) begin
         held_next.unit = dmmlcd_pkg::UNIT_AMP;
      end else if (frame[12][2]) begin
         held_next.unit = dmmlcd_pkg::UNIT_VOLT;
      end else if (frame[12][1]) begin
         held_next.unit = dmmlcd_pkg::UNIT_HERTZ;
      end else begin
         // No unit flag is set, so the held or temperature unit stands.
      end

      // A reading with a bad digit keeps the last good value.
      if (all_ok) begin
         held_next.magnitude = magnitude;
         held_next.decimals = places;
         held_next.negative = frame[1][3];
      end
   end

   // Result fields.
   always_comb begin
      result.reading_magnitude = held_next.magnitude;
      result.decimal_places = held_next.decimals;
      result.negative = held_next.negative;
      result.reading_valid = all_ok;
      result.meas_mode = held_next.mode;
      result.scale_prefix = held_next.prefix;
      result.meas_unit = held_next.unit;
      result.auto_range = frame[0][1];
   end

endmodule

`default_nettype wire

// ----- src/dmm_lcd_frame_decoder.sv -----
// Top level of the meter frame decoder: input register, frame store and result register.
`default_nettype none

// Takes one serial byte of the meter's LCD frame per transfer on req_chan and returns one
// decoded reading per 14-byte frame on rsp_chan. While hunting, bytes whose high nibble is
// not 1 are dropped; a byte with high nibble 1 starts a frame and the next thirteen bytes
// complete it unchecked. A byte can be taken in every clock cycle unless a stalled fourteenth
// byte holds the input register. Each byte passes through the input register; the fourteenth
// byte is decoded from there in a single pass into the result register, which drives rsp_chan.
// The result register lets the next frame's bytes flow in while a reading waits; only a
// fourteenth byte that meets a still-occupied result register waits in the input register.
// Mode, prefix and unit keep their last values when a frame sets none of their flags, and a
// frame with a bad digit reports reading_valid low with the last good reading.
module dmm_lcd_frame_decoder (
   input wire logic clock,
   input wire logic reset,
   dmmlcd_chan_if.sink   req_chan,
   dmmlcd_chan_if.source rsp_chan
);

   // Input register.
   logic                 s1_valid_ff, s1_valid_in;
   dmmlcd_pkg::req_type  s1_ff;
   logic                 s1_last;
   logic                 s1_fire;
   logic                 req_fire;

   // Frame position and stored bytes.
   logic [3:0]           count_ff, count_in;
   logic [7:0]           store_ff [dmmlcd_pkg::StoreDepth];
   logic [7:0]           frame [dmmlcd_pkg::FrameLen];

   // Persistent decode values and the result register.
   dmmlcd_pkg::held_type held_ff, held_in;
   dmmlcd_pkg::held_type held_next;
   dmmlcd_pkg::rsp_type  rsp_ff;
   dmmlcd_pkg::rsp_type  decoded;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 load_rsp;

   // Handshake control.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_last = (count_ff == dmmlcd_pkg::LastIndex);
   assign s1_fire = s1_valid_ff && (!s1_last || out_free);
   assign load_rsp = s1_fire && s1_last;
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Frame position: hunt for a start byte, then count up to the last byte.
   always_comb begin
      count_in = count_ff;
      if (s1_fire) begin
         priority if (count_ff == 4'd0) begin
            count_in = (s1_ff.rx_byte[7:4] == dmmlcd_pkg::StartNibble) ? 4'd1 : 4'd0;
         end else if (s1_last) begin
            count_in = 4'd0;
         end else begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   // The full frame: stored bytes plus the last byte still in the input register.
   always_comb begin
      for (int i = 0; i < dmmlcd_pkg::StoreDepth; i++) begin
         frame[i] = store_ff[i];
      end
      frame[dmmlcd_pkg::StoreDepth] = s1_ff.rx_byte;
   end

   dmmlcd_decode u_decode (
      .frame     (frame),
      .held      (held_ff),
      .held_next (held_next),
      .result    (decoded)
   );

   assign held_in = load_rsp ? held_next : held_ff;

   // Result register occupancy.
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
         held_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff <= held_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= req_chan.payload;
      end
      if (load_rsp) begin
         rsp_ff <= decoded;
      end
   end

   // Frame store: bytes before the last one land at their frame position.
   always_ff @(posedge clock) begin
      if (s1_fire && !s1_last && (count_ff != 4'd0 ||
          s1_ff.rx_byte[7:4] == dmmlcd_pkg::StartNibble)) begin
         store_ff[count_ff] <= s1_ff.rx_byte;
      end
   end

   // A decoded last byte always produces a waiting result.
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && count_ff == 4'd0)
      else $error("last frame byte did not produce a result");

   // A byte that is not a start byte is dropped while hunting.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && count_ff == 4'd0 && s1_ff.rx_byte[7:4] != dmmlcd_pkg::StartNibble
      |=> count_ff == 4'd0)
      else $error("non-start byte opened a frame");

   // Inside a frame every passed byte advances the position by one.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && count_ff != 4'd0 && !s1_last |=> count_ff == $past(count_ff) + 4'd1)
      else $error("frame position did not advance");

   // A stalled last byte must not move on.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last && !out_free |=> s1_valid_ff && s1_last)
      else $error("last frame byte left the input register while the result was blocked");

   // A reading reported as valid is always a four-digit value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reading_valid |->
         rsp_ff.reading_magnitude <= dmmlcd_pkg::MaxMagnitude)
      else $error("valid reading out of range");

endmodule

`default_nettype wire
